// ===== rtl/shortest_path_distances_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path distances block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_PATH_DISTANCES_ASSERT_SVH
`define SHORTEST_PATH_DISTANCES_ASSERT_SVH

// same-cycle implication, off during reset
`define SPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// what must follow a cycle in reset
`define SPD_ASSERT_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest path distances package
// Request and result types, work entry layout and the sequencer microcode.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int NUM_VERTICES_DEFAULT = 16;

   localparam int VERTEX_W = 4;
   localparam int DIST_W   = 12;
   localparam int WEIGHT_W = 8;
   localparam int KEY_W    = DIST_W + 1;

   localparam logic [DIST_W-1:0] DIST_UNREACHABLE = 12'hFFF;
   localparam logic [DIST_W-1:0] DIST_SAT_MAX     = 12'hFFE;
   localparam logic [KEY_W-1:0]  KEY_UNREACHED    = 13'h1000;
   localparam logic [KEY_W-1:0]  KEY_WORST        = 13'h1FFF;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   typedef struct packed {
      logic                op;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [WEIGHT_W-1:0] weight;
      logic                both_ways;
      logic [VERTEX_W-1:0] source;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [DIST_W-1:0]   distance;
      logic                reachable;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic              settled;
      logic              reach;
      logic [DIST_W-1:0] path_len;
   } work_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WRITE_FWD,
      ST_WRITE_REV,
      ST_INIT,
      ST_ROUND_START,
      ST_PICK,
      ST_MARK,
      ST_RELAX,
      ST_NEXT_ROUND,
      ST_OUT_START,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_NEXT,
      ST_OUT_DONE
   } step_type;

   typedef enum logic [3:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_CLEAR_RUN,
      JMP_NO_REQUEST,
      JMP_OP_RUN,
      JMP_NOT_BOTH,
      JMP_BEFORE_LAST,
      JMP_BEFORE_END,
      JMP_NOT_REACHED,
      JMP_ROUNDS_LEFT,
      JMP_SLOT_BUSY
   } jump_type;

   typedef struct packed {
      jump_type jump;
      step_type target;
      logic     take_req;
      logic     cnt_clr;
      logic     cnt_inc;
      logic     clear_wr;
      logic     write_fwd;
      logic     write_rev;
      logic     init_wr;
      logic     scan_rd;
      logic     pick_en;
      logic     best_init;
      logic     mark_wr;
      logic     relax_en;
      logic     round_clr;
      logic     round_inc;
      logic     out_load;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      cw = '0;
      unique case (step)
         ST_CLEAR: begin
            cw.clear_wr = 1'b1;
            cw.jump     = JMP_CLEAR_RUN;
            cw.target   = ST_CLEAR;
         end
         ST_IDLE: begin
            cw.take_req = 1'b1;
            cw.cnt_clr  = 1'b1;
            cw.jump     = JMP_NO_REQUEST;
            cw.target   = ST_IDLE;
         end
         ST_DISPATCH: begin
            cw.jump   = JMP_OP_RUN;
            cw.target = ST_INIT;
         end
         ST_WRITE_FWD: begin
            cw.write_fwd = 1'b1;
            cw.jump      = JMP_NOT_BOTH;
            cw.target    = ST_IDLE;
         end
         ST_WRITE_REV: begin
            cw.write_rev = 1'b1;
            cw.jump      = JMP_ALWAYS;
            cw.target    = ST_IDLE;
         end
         ST_INIT: begin
            cw.init_wr = 1'b1;
            cw.cnt_inc = 1'b1;
            cw.jump    = JMP_BEFORE_LAST;
            cw.target  = ST_INIT;
         end
         ST_ROUND_START: begin
            cw.cnt_clr   = 1'b1;
            cw.best_init = 1'b1;
            cw.round_clr = 1'b1;
         end
         ST_PICK: begin
            cw.scan_rd = 1'b1;
            cw.pick_en = 1'b1;
            cw.cnt_inc = 1'b1;
            cw.jump    = JMP_BEFORE_END;
            cw.target  = ST_PICK;
         end
         ST_MARK: begin
            cw.mark_wr = 1'b1;
            cw.cnt_clr = 1'b1;
            cw.jump    = JMP_NOT_REACHED;
            cw.target  = ST_NEXT_ROUND;
         end
         ST_RELAX: begin
            cw.scan_rd  = 1'b1;
            cw.relax_en = 1'b1;
            cw.cnt_inc  = 1'b1;
            cw.jump     = JMP_BEFORE_END;
            cw.target   = ST_RELAX;
         end
         ST_NEXT_ROUND: begin
            cw.cnt_clr   = 1'b1;
            cw.best_init = 1'b1;
            cw.round_inc = 1'b1;
            cw.jump      = JMP_ROUNDS_LEFT;
            cw.target    = ST_PICK;
         end
         ST_OUT_START: begin
            cw.cnt_clr = 1'b1;
         end
         ST_OUT_READ: begin
            cw.scan_rd = 1'b1;
         end
         ST_OUT_LOAD: begin
            cw.out_load = 1'b1;
            cw.jump     = JMP_SLOT_BUSY;
            cw.target   = ST_OUT_LOAD;
         end
         ST_OUT_NEXT: begin
            cw.jump   = JMP_BEFORE_END;
            cw.target = ST_OUT_READ;
         end
         ST_OUT_DONE: begin
            cw.jump   = JMP_ALWAYS;
            cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/shortest_path_distances.sv =====
// ----------------------------------------------------------------------------
// Shortest path distances
// Single-source shortest paths over a stored weighted adjacency matrix.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid / req_stall / req_data; results leave on
// rsp_valid / rsp_stall / rsp_data. A request is taken at an edge with valid
// high and stall low. A write request (op 0) stores one edge weight, and the
// mirrored one when both_ways is set, and gives no result. A run request (op 1)
// gives one result per vertex in ascending order, last set on the final one.
// Each of the N-1 rounds of a run scans the work memory once to pick the
// vertex and, when it is reached, once more to relax its row, one vertex a
// cycle through the single read port; results leave one at a time, each
// waiting for the output register to be free.
// Reset starts a clearing pass over the edge memory, during which req_stall
// stays high.
// A stalled result holds in the output register; the sequencer waits on it,
// and after loading the final result it steps through ST_OUT_NEXT and ST_OUT_DONE
// to idle and takes the next request without waiting for that result to leave.
// ----------------------------------------------------------------------------
module shortest_path_distances #(
   parameter int NUM_VERTICES = spd_pkg::NUM_VERTICES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spd_pkg::rsp_type rsp_data
);

   localparam int VW    = $clog2(NUM_VERTICES);
   localparam int CW    = $clog2(NUM_VERTICES + 1);
   localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [CW-1:0] CNT_LAST   = CW'(NUM_VERTICES - 1);
   localparam logic [CW-1:0] CNT_END    = CW'(NUM_VERTICES);
   localparam logic [VW-1:0] ROUND_LAST = VW'(NUM_VERTICES - 2);
   localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(NUM_VERTICES);

   spd_pkg::step_type  step_ff, step_in;
   spd_pkg::ucode_type cw;
   logic               jump_taken;

   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] round_ff, round_in;
   logic [VW-1:0] best_idx_ff, best_idx_in;
   logic [spd_pkg::KEY_W-1:0] best_key_ff, best_key_in;
   spd_pkg::req_type req_ff, req_in;
   spd_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [spd_pkg::WEIGHT_W-1:0] edge_mem [DEPTH];
   logic [spd_pkg::WEIGHT_W-1:0] edge_q_ff;
   spd_pkg::work_type            work_mem [NUM_VERTICES];
   spd_pkg::work_type            work_q_ff;

   logic                         req_acc;
   logic                         slot_free;
   logic                         pipe_valid;
   logic                         at_end;
   logic                         in_range;
   logic [VW-1:0]                cnt_idx;
   logic [VW-1:0]                prev_idx;
   logic [spd_pkg::KEY_W-1:0]    cand_key;
   logic [spd_pkg::KEY_W-1:0]    sum_wide;
   logic [spd_pkg::DIST_W-1:0]   sum_sat;
   logic                         pick_hit;
   logic                         relax_hit;
   logic                         out_take;

   logic                         edge_we;
   logic                         edge_re;
   logic [AW-1:0]                edge_waddr;
   logic [AW-1:0]                edge_raddr;
   logic [spd_pkg::WEIGHT_W-1:0] edge_wdata;
   logic                         work_we;
   logic                         work_re;
   logic [VW-1:0]                work_waddr;
   spd_pkg::work_type            work_wdata;

   // control word of the current step
   always_comb begin
      cw = spd_pkg::ucode_rom(step_ff);
   end

   // next step
   always_comb begin
      unique case (cw.jump)
         spd_pkg::JMP_NEVER:       jump_taken = 1'b0;
         spd_pkg::JMP_ALWAYS:      jump_taken = 1'b1;
         spd_pkg::JMP_CLEAR_RUN:   jump_taken = clr_ff != CLR_LAST;
         spd_pkg::JMP_NO_REQUEST:  jump_taken = !req_acc;
         spd_pkg::JMP_OP_RUN:      jump_taken = req_ff.op == spd_pkg::OP_RUN;
         spd_pkg::JMP_NOT_BOTH:    jump_taken = !req_ff.both_ways;
         spd_pkg::JMP_BEFORE_LAST: jump_taken = cnt_ff != CNT_LAST;
         spd_pkg::JMP_BEFORE_END:  jump_taken = !at_end;
         spd_pkg::JMP_NOT_REACHED: jump_taken = best_key_ff[spd_pkg::KEY_W-1];
         spd_pkg::JMP_ROUNDS_LEFT: jump_taken = round_ff != ROUND_LAST;
         spd_pkg::JMP_SLOT_BUSY:   jump_taken = !slot_free;
         default:                  jump_taken = 1'b0;
      endcase
      step_in = jump_taken ? cw.target : spd_pkg::step_type'(4'(step_ff) + 4'd1);
   end

   // datapath
   always_comb begin
      req_stall  = !cw.take_req;
      req_acc    = req_valid && cw.take_req;
      slot_free  = !rsp_valid_ff || !rsp_stall;
      out_take   = cw.out_load && slot_free;
      at_end     = cnt_ff == CNT_END;
      pipe_valid = cnt_ff != '0;
      cnt_idx    = cnt_ff[VW-1:0];
      prev_idx   = VW'(cnt_ff - 1'b1);
      in_range   = (32'(req_ff.from_vertex) < NUM_VERTICES)
                && (32'(req_ff.to_vertex) < NUM_VERTICES);

      cand_key  = work_q_ff.reach ? {1'b0, work_q_ff.path_len} : spd_pkg::KEY_UNREACHED;
      pick_hit  = cw.pick_en && pipe_valid && !work_q_ff.settled
               && (cand_key <= best_key_ff);

      sum_wide  = {1'b0, best_key_ff[spd_pkg::DIST_W-1:0]}
               + spd_pkg::KEY_W'(edge_q_ff);
      sum_sat   = (sum_wide > {1'b0, spd_pkg::DIST_SAT_MAX}) ? spd_pkg::DIST_SAT_MAX
                                                          : sum_wide[spd_pkg::DIST_W-1:0];
      relax_hit = cw.relax_en && pipe_valid && !work_q_ff.settled
               && (edge_q_ff != '0)
               && (!work_q_ff.reach || (sum_sat < work_q_ff.path_len));

      req_in = req_acc ? req_data : req_ff;

      clr_in = cw.clear_wr ? clr_ff + 1'b1 : clr_ff;

      priority if (cw.cnt_clr) begin
         cnt_in = '0;
      end else if (cw.cnt_inc || out_take) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end

      priority if (cw.round_clr) begin
         round_in = '0;
      end else if (cw.round_inc) begin
         round_in = round_ff + 1'b1;
      end else begin
         round_in = round_ff;
      end

      priority if (cw.best_init) begin
         best_idx_in = '0;
         best_key_in = spd_pkg::KEY_WORST;
      end else if (pick_hit) begin
         best_idx_in = prev_idx;
         best_key_in = cand_key;
      end else begin
         best_idx_in = best_idx_ff;
         best_key_in = best_key_ff;
      end

      rsp_in = rsp_ff;
      if (out_take) begin
         rsp_in.vertex    = spd_pkg::VERTEX_W'(cnt_idx);
         rsp_in.distance  = work_q_ff.reach ? work_q_ff.path_len : spd_pkg::DIST_UNREACHABLE;
         rsp_in.reachable = work_q_ff.reach;
         rsp_in.last      = cnt_ff == CNT_LAST;
      end
      rsp_valid_in = out_take || (rsp_valid_ff && rsp_stall);

      edge_re    = cw.scan_rd && !at_end;
      edge_raddr = AW'(best_idx_ff) * ROW_STRIDE + AW'(cnt_idx);
      edge_we    = cw.clear_wr || ((cw.write_fwd || cw.write_rev) && in_range);
      priority if (cw.clear_wr) begin
         edge_waddr = clr_ff;
         edge_wdata = '0;
      end else if (cw.write_rev) begin
         edge_waddr = AW'(req_ff.to_vertex) * ROW_STRIDE + AW'(req_ff.from_vertex);
         edge_wdata = req_ff.weight;
      end else begin
         edge_waddr = AW'(req_ff.from_vertex) * ROW_STRIDE + AW'(req_ff.to_vertex);
         edge_wdata = req_ff.weight;
      end

      work_re = cw.scan_rd && !at_end;
      work_we = cw.init_wr || cw.mark_wr || relax_hit;
      priority if (cw.init_wr) begin
         work_waddr          = cnt_idx;
         work_wdata.settled  = 1'b0;
         work_wdata.reach    = 32'(cnt_idx) == 32'(req_ff.source);
         work_wdata.path_len = '0;
      end else if (cw.mark_wr) begin
         work_waddr          = best_idx_ff;
         work_wdata.settled  = 1'b1;
         work_wdata.reach    = !best_key_ff[spd_pkg::KEY_W-1];
         work_wdata.path_len = best_key_ff[spd_pkg::DIST_W-1:0];
      end else begin
         work_waddr          = prev_idx;
         work_wdata.settled  = 1'b0;
         work_wdata.reach    = 1'b1;
         work_wdata.path_len = sum_sat;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (edge_re) begin
         edge_q_ff <= edge_mem[edge_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      if (work_re) begin
         work_q_ff <= work_mem[cnt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= spd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
   end

endmodule

// ===== rtl/spd_checker.sv =====
// ----------------------------------------------------------------------------
// Shortest path distances port checker
// Watches the top level's ports and flags broken result handshake, encoding or reset.
// ----------------------------------------------------------------------------
`include "shortest_path_distances_assert.svh"

module spd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spd_pkg::rsp_type rsp_data
);

   `SPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

   `SPD_ASSERT_IMPLY(a_busy_mid_run, clock, reset, rsp_valid && !rsp_data.last, req_stall, "request open while a run is still emitting")

   `SPD_ASSERT_IMPLY(a_reach_code, clock, reset, rsp_valid && req_valid, rsp_data.reachable == (rsp_data.distance != spd_pkg::DIST_UNREACHABLE), "reachable flag disagrees with distance")

   `SPD_ASSERT_IMPLY(a_reach_code_idle, clock, reset, rsp_valid && !req_valid, rsp_data.reachable == (rsp_data.distance != spd_pkg::DIST_UNREACHABLE), "reachable flag disagrees with distance")

   `SPD_ASSERT_RESET(a_reset_quiet, clock, reset, !rsp_valid && req_stall, "block not quiet after reset")

endmodule

bind shortest_path_distances spd_checker u_spd_checker (.*);
